/* hw/rtl/kfa_pkg.sv */
// Shared types and constants of the diagnostic frame assembler.
`default_nettype none
package kfa_pkg;

    localparam logic [7:0] FMT_BASE  = 8'h80;
    localparam logic [7:0] LEN_MASK  = 8'h3F;
    localparam int         MAX_BYTES = 6;
    localparam int         CNT_W     = 3;
    localparam int         IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [IDX_W-1:0] REG_SOURCE = 2'd1;
    localparam logic [IDX_W-1:0] REG_LONG   = 2'd2;

    typedef struct packed {
        logic [7:0] target_address;
        logic [7:0] source_address;
        logic       long_header;
    } t_cfg;

    // Bytes caused by one input word, in output order.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      has_chk;
        logic                      err;
    } t_burst;

endpackage
`default_nettype wire

/* hw/rtl/kfa_cfg_regs.sv */
// Configuration register file of the frame assembler.
`default_nettype none
module kfa_cfg_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    input  wire logic [kfa_pkg::IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                i_cfg_data,
    output kfa_pkg::t_cfg                  o_cfg
);

    kfa_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                kfa_pkg::REG_TARGET: r_cfg.target_address <= i_cfg_data;
                kfa_pkg::REG_SOURCE: r_cfg.source_address <= i_cfg_data;
                kfa_pkg::REG_LONG:   r_cfg.long_header    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* hw/rtl/kfa_frame_build.sv */
// Frame state and composition of the byte burst for each input word.
`default_nettype none
module kfa_frame_build (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  kfa_pkg::t_cfg      i_cfg,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_payload_byte,
    input  wire logic [7:0]    i_frame_length,
    input  wire logic          i_burst_done,
    output logic               o_burst_valid,
    output kfa_pkg::t_burst    o_burst
);

    logic            r_in_frame, n_in_frame;
    logic [7:0]      r_bytes_left, n_bytes_left;
    logic [7:0]      r_sum, n_sum;
    logic            r_burst_valid;
    kfa_pkg::t_burst r_burst, n_burst;

    logic                     w_accept;
    logic [7:0]               w_len;
    logic [7:0]               w_cnt;
    logic [7:0]               w_total;
    logic [kfa_pkg::CNT_W-1:0] w_pos;
    logic                     w_chk;

    assign o_ready  = !r_burst_valid || i_burst_done;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_burst = '0;
        w_len   = (i_frame_length == 8'd0) ? 8'd1 : i_frame_length;
        if (!r_in_frame) begin
            n_burst.err      = !i_cfg.long_header && (w_len > kfa_pkg::LEN_MASK);
            n_burst.bytes[0] = kfa_pkg::FMT_BASE | (w_len & kfa_pkg::LEN_MASK);
            n_burst.bytes[1] = i_cfg.target_address;
            n_burst.bytes[2] = i_cfg.source_address;
            w_total = n_burst.bytes[0] + i_cfg.target_address + i_cfg.source_address
                    + i_payload_byte;
            if (i_cfg.long_header) begin
                n_burst.bytes[3] = w_len;
                n_burst.bytes[4] = i_payload_byte;
                w_total          = w_total + w_len;
                w_pos            = 3'd5;
            end else begin
                n_burst.bytes[3] = i_payload_byte;
                w_pos            = 3'd4;
            end
            w_cnt = w_len;
        end else begin
            n_burst.bytes[0] = i_payload_byte;
            w_total          = r_sum + i_payload_byte;
            w_pos            = 3'd1;
            w_cnt            = r_bytes_left;
        end
        n_bytes_left = (w_cnt != 8'd0) ? w_cnt - 8'd1 : 8'd0;
        w_chk        = (n_bytes_left == 8'd0);
        if (w_chk) begin
            n_burst.bytes[w_pos] = w_total;
        end
        n_burst.has_chk = w_chk;
        n_burst.count   = w_pos + {{(kfa_pkg::CNT_W-1){1'b0}}, w_chk};
        n_in_frame      = !w_chk;
        n_sum           = w_chk ? 8'd0 : w_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame    <= 1'b0;
            r_bytes_left  <= 8'd0;
            r_sum         <= 8'd0;
            r_burst_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_frame    <= n_in_frame;
            r_bytes_left  <= n_bytes_left;
            r_sum         <= n_sum;
            r_burst_valid <= 1'b1;
        end else if (i_burst_done) begin
            r_burst_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_burst <= n_burst;
        end
    end

    assign o_burst_valid = r_burst_valid;
    assign o_burst       = r_burst;

endmodule
`default_nettype wire

/* hw/rtl/kfa_out_stage.sv */
// Walks a byte burst one word per cycle into the output register, stalling while i_ready is low.
`default_nettype none
module kfa_out_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_burst_valid,
    input  kfa_pkg::t_burst i_burst,
    output logic            o_burst_done,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_frame_byte,
    output logic            o_frame_last,
    output logic            o_length_error
);

    logic [kfa_pkg::CNT_W-1:0] r_idx;
    logic                      r_valid;
    logic [7:0]                r_byte;
    logic                      r_last;
    logic                      r_err;
    logic                      w_load;
    logic                      w_final;

    assign w_load       = i_burst_valid && (!r_valid || i_ready);
    assign w_final      = (r_idx == i_burst.count - 3'd1);
    assign o_burst_done = w_load && w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_final ? '0 : r_idx + 3'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_burst.bytes[r_idx];
            r_last <= w_final && i_burst.has_chk;
            r_err  <= i_burst.err;
        end
    end

    assign o_valid        = r_valid;
    assign o_frame_byte   = r_byte;
    assign o_frame_last   = r_last;
    assign o_length_error = r_err;

endmodule
`default_nettype wire

/* hw/rtl/kwp_frame_assembler.sv */
// Top level of the diagnostic request frame assembler.
//
//  channel | dir | handshake                 | word
//  --------+-----+---------------------------+-----------------------------------
//  in      | in  | i_in_valid / o_in_ready   | i_payload_byte, i_frame_length
//  out     | out | o_out_valid / i_out_ready | o_frame_byte, o_frame_last,
//          |     |                           | o_length_error
//  cfg     | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each input word is turned into a burst of 1 to 6 output words
// (header, payload byte, checksum), held in the burst register. The output
// stage moves one word per cycle into the output register while it is free or
// i_out_ready is high; an input word causes 1 word mid-frame, 2 on the last byte of
// a frame, up to 6 on the first byte of a one-byte long-header frame. The
// single output port sets the pace at which input words are taken.
// A new input word is taken in the cycle the last word of the current burst
// moves out, even while the output register still waits on i_out_ready.
// Synchronous active-low reset clears frame state, burst and output valids
// and all configuration registers. Config writes are always ready.
`default_nettype none
module kwp_frame_assembler (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [7:0]                i_payload_byte,
    input  wire logic [7:0]                i_frame_length,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [7:0]                     o_frame_byte,
    output logic                           o_frame_last,
    output logic                           o_length_error,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [kfa_pkg::IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                i_cfg_data
);

    kfa_pkg::t_cfg   w_cfg;
    kfa_pkg::t_burst w_burst;
    logic            w_burst_valid;
    logic            w_burst_done;

    assign o_cfg_ready = 1'b1;

    kfa_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // frame state, header insertion and checksum
    kfa_frame_build u_build (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_payload_byte (i_payload_byte),
        .i_frame_length (i_frame_length),
        .i_burst_done   (w_burst_done),
        .o_burst_valid  (w_burst_valid),
        .o_burst        (w_burst)
    );

    // burst serializer and output register
    kfa_out_stage u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_burst_valid  (w_burst_valid),
        .i_burst        (w_burst),
        .o_burst_done   (w_burst_done),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_frame_byte   (o_frame_byte),
        .o_frame_last   (o_frame_last),
        .o_length_error (o_length_error)
    );

endmodule
`default_nettype wire

/* sim/tb_kwp_frame_assembler.sv */
// Self-checking testbench of the diagnostic request frame assembler.
`timescale 1ns / 1ps
`default_nettype none
module tb_kwp_frame_assembler;

    // Index that maps to no register; writes to it must be dropped.
    localparam logic [kfa_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
    // Cycles without any handshake before the run is declared hung. The
    // longest legal quiet span is the receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TARGET_WORDS   = 330;
    // Rough share of the total left for the closing phases.
    localparam int FINAL_WORDS    = 60;
    localparam int IDLE_PERCENT   = 10;

    // One input word: payload byte plus the frame length field.
    typedef struct {
        logic [7:0] data;
        logic [7:0] len;
    } t_payload_word;

    // One expected output word.
    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       err;
    } t_frame_word;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_ready;
    logic [7:0]                    i_payload_byte = '0;
    logic [7:0]                    i_frame_length = '0;
    logic                          o_out_valid;
    logic                          i_out_ready    = 1'b0;
    logic [7:0]                    o_frame_byte;
    logic                          o_frame_last;
    logic                          o_length_error;
    logic                          i_cfg_valid    = 1'b0;
    logic                          o_cfg_ready;
    logic [kfa_pkg::IDX_W-1:0]     i_cfg_index    = '0;
    logic [7:0]                    i_cfg_data     = '0;

    kwp_frame_assembler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_payload_byte (i_payload_byte),
        .i_frame_length (i_frame_length),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_byte   (o_frame_byte),
        .o_frame_last   (o_frame_last),
        .o_length_error (o_length_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Words waiting to be offered, and frame words the block still owes us.
    t_payload_word pending_words[$];
    t_frame_word   expected_words[$];
    t_payload_word next_word;

    int words_queued  = 0;
    int words_taken   = 0;
    int words_seen    = 0;
    int mismatches    = 0;
    int stall_cycles  = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;
    bit quiet         = 1'b0;  // no random idling on either side

    // Predictor copy of the configuration and the frame state.
    logic [7:0] cfg_target = '0;
    logic [7:0] cfg_source = '0;
    logic       cfg_long   = 1'b0;
    logic       in_frame   = 1'b0;
    logic [7:0] bytes_left = '0;
    logic [7:0] frame_sum  = '0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH word %0d: %s", $realtime, words_seen, msg);
        mismatches++;
    endtask

    // Every emitted byte, the checksum too, goes into the running sum.
    task automatic emit_word(input logic [7:0] value, input logic last, input logic err);
        t_frame_word w;
        w.value = value;
        w.last  = last;
        w.err   = err;
        expected_words.push_back(w);
        frame_sum = frame_sum + value;
    endtask

    // Expected frame words caused by one accepted input word.
    task automatic assemble_frame_words(input logic [7:0] data, input logic [7:0] len_in);
        logic [7:0] len;
        logic       err;
        len = len_in;
        err = 1'b0;
        if (!in_frame) begin
            // zero length counts as one; length only matters on the first byte
            if (len == 8'd0) len = 8'd1;
            err = !cfg_long && (len > kfa_pkg::LEN_MASK);
            frame_sum = '0;
            emit_word(kfa_pkg::FMT_BASE | (len & kfa_pkg::LEN_MASK), 1'b0, err);
            emit_word(cfg_target, 1'b0, err);
            emit_word(cfg_source, 1'b0, err);
            if (cfg_long) emit_word(len, 1'b0, err);
            in_frame   = 1'b1;
            bytes_left = len;
        end
        emit_word(data, 1'b0, err);
        if (bytes_left > 0) bytes_left = bytes_left - 8'd1;
        if (bytes_left == 0) begin
            emit_word(frame_sum, 1'b1, err);
            in_frame  = 1'b0;
            frame_sum = '0;
        end
    endtask

    // Input driver: holds valid and payload until the word is taken, then
    // pulls the next one from the pending queue or idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                assemble_frame_words(i_payload_byte, i_frame_length);
                words_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_words.size() > 0 &&
                    (quiet || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    next_word = pending_words.pop_front();
                    i_in_valid     <= 1'b1;
                    i_payload_byte <= next_word.data;
                    i_frame_length <= next_word.len;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each taken word against the oldest expectation
    // and drives ready with random stalls plus one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word byte=%02h", o_frame_byte));
                end else begin
                    if (o_frame_byte !== expected_words[0].value)
                        report_mismatch($sformatf("frame_byte %02h, want %02h",
                                                  o_frame_byte, expected_words[0].value));
                    if (o_frame_last !== expected_words[0].last)
                        report_mismatch($sformatf("frame_last %b, want %b",
                                                  o_frame_last, expected_words[0].last));
                    if (o_length_error !== expected_words[0].err)
                        report_mismatch($sformatf("length_error %b, want %b",
                                                  o_length_error, expected_words[0].err));
                    void'(expected_words.pop_front());
                end
                words_seen++;
            end
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: any handshake counts as progress.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT) begin
                    $display("[%0t] watchdog: no handshake for %0d cycles",
                             $realtime, stall_cycles);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    task automatic queue_word(input logic [7:0] data, input logic [7:0] len);
        t_payload_word w;
        w.data = data;
        w.len  = len;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Whole frame, random content; later bytes carry junk length fields.
    task automatic queue_frame(input logic [7:0] len);
        int n;
        n = (len == 8'd0) ? 1 : int'(len);
        queue_word(8'($urandom_range(0, 255)), len);
        for (int i = 1; i < n; i++)
            queue_word(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Mostly short frames, some mid-sized ones, and a rare long one that can cross the six-bit limit.
    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 8'd0;
        if (r < 80) return 8'($urandom_range(1, 6));
        if (r < 95) return 8'($urandom_range(7, 20));
        return 8'($urandom_range(21, 70));
    endfunction

    function automatic logic [7:0] pick_address();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Sender pause: nothing outstanding on either channel.
    task automatic wait_idle();
        while (words_taken != words_queued || expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [kfa_pkg::IDX_W-1:0] idx, input logic [7:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            kfa_pkg::REG_TARGET: cfg_target = data;
            kfa_pkg::REG_SOURCE: cfg_source = data;
            kfa_pkg::REG_LONG:   cfg_long   = data[0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [7:0] tgt, input logic [7:0] src,
                                input logic lng);
        write_reg(kfa_pkg::REG_TARGET, tgt);
        write_reg(kfa_pkg::REG_SOURCE, src);
        write_reg(kfa_pkg::REG_LONG, {7'($urandom_range(0, 127)), lng});
    endtask

    initial begin
        int phase_words;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: zero addresses, short mode.
        queue_word(8'h00, 8'd1);
        wait_idle();

        // Short mode, extreme addresses; zero length and ignored later lengths.
        write_config(8'hFF, 8'h00, 1'b0);
        write_reg(REG_UNUSED, 8'h5A);
        queue_word(8'hFF, 8'd0);
        queue_word(8'h00, 8'd2);
        queue_word(8'hFF, 8'hFF);
        queue_word(8'h3E, 8'd63);
        queue_word(8'hC1, 8'd0);
        queue_word(8'h81, 8'd1);
        wait_idle();

        // Long mode; these bytes still fall inside the 63-byte frame opened above.
        write_config(8'h00, 8'hFF, 1'b1);
        queue_word(8'h10, 8'd1);
        queue_word(8'hAA, 8'd3);
        queue_word(8'h55, 8'd1);
        queue_word(8'h7F, 8'd200);
        wait_idle();

        // Config write in the middle of a frame only shows in the next header.
        queue_word(8'h22, 8'd3);
        wait_idle();
        write_config(8'hA5, 8'h5A, 1'b0);
        write_reg(REG_UNUSED, 8'hFF);
        queue_word(8'h33, 8'd0);
        queue_word(8'h44, 8'hFF);
        queue_word(8'h01, 8'd2);
        queue_word(8'hFE, 8'd9);
        wait_idle();

        // Short mode; a 100-byte frame, whose first bytes still close the frame left open above.
        write_config(pick_address(), pick_address(), 1'b0);
        queue_frame(8'd100);
        wait_idle();

        // Long header with a length past six bits, no idling in this stretch.
        quiet = 1'b1;
        write_config(pick_address(), pick_address(), 1'b1);
        queue_frame(8'd64);
        wait_idle();
        quiet = 1'b0;

        // Random phases; the first one runs into the receiver hold-off.
        while (words_queued < TARGET_WORDS - FINAL_WORDS) begin
            write_config(pick_address(), pick_address(), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
            if (!hold_done) hold_req = 1'b1;
            phase_words = 0;
            while (phase_words < 40) begin
                queue_frame(pick_length());
                phase_words = phase_words + pending_words.size() - phase_words;
            end
            wait_idle();
        end

        // Back to the extreme settings for the final phases.
        write_config(8'hFF, 8'hFF, 1'b1);
        for (int i = 0; i < 3; i++) queue_frame(pick_length());
        wait_idle();
        write_config(8'h00, 8'h00, 1'b0);
        for (int i = 0; i < 3; i++) queue_frame(pick_length());
        wait_idle();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
hw/rtl/kfa_pkg.sv
hw/rtl/kfa_cfg_regs.sv
hw/rtl/kfa_frame_build.sv
hw/rtl/kfa_out_stage.sv
hw/rtl/kwp_frame_assembler.sv
sim/tb_kwp_frame_assembler.sv
